@@ src/unsigned_divide_32_by_16_overflow_defines.svh @@
// ----------------------------------------------------------------------------
// unsigned divide assertion macros
// concurrent assertion helpers, clocked on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_DIVIDE_32_BY_16_OVERFLOW_DEFINES_SVH
`define UNSIGNED_DIVIDE_32_BY_16_OVERFLOW_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define UD32_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define UD32_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define UD32_ASSERT_IMPL(lbl, ante, cons, msg)
`define UD32_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/ud32_pkg.sv @@
// ----------------------------------------------------------------------------
// ud32_pkg
// widths, queue depths and item types of the unsigned divider
// ----------------------------------------------------------------------------
package ud32_pkg;

  localparam int WORD_BITS = 16;
  localparam int MID_DEPTH = 2;
  // pipeline stages plus room to cover pop latency
  localparam int OUT_DEPTH = WORD_BITS + 2;

  typedef struct packed {
    logic [2*WORD_BITS-1:0] dividend;
    logic [WORD_BITS-1:0]   divisor;
  } request_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] quotient;
    logic [WORD_BITS-1:0] remainder;
    logic                 overflow;
  } result_t;

  // classified item between front and back, and the state of one division step
  typedef struct packed {
    logic                 overflow;
    logic [WORD_BITS-1:0] divisor;
    logic [WORD_BITS-1:0] rem;
    logic [WORD_BITS-1:0] quo;
  } work_t;

endpackage

@@ src/ud32_queue.sv @@
// ----------------------------------------------------------------------------
// ud32_queue
// small first-in first-out queue of registers with full and empty flags
// ----------------------------------------------------------------------------
module ud32_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == CNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

@@ src/ud32_front.sv @@
// ----------------------------------------------------------------------------
// ud32_front
// takes request items, flags overflow and hands classified items onward
// ----------------------------------------------------------------------------
module ud32_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  ud32_pkg::request_t  request,
  output logic                work_push,
  input  logic                work_full,
  output ud32_pkg::work_t     work
);

  import ud32_pkg::*;

  logic  valid;
  logic  load;
  work_t work_next;

  assign full      = valid && work_full;
  assign load      = push && !full;
  assign work_push = valid;

  // overflow when the divisor does not exceed the high word, zero included
  always_comb begin
    work_next.rem      = request.dividend[2*WORD_BITS-1:WORD_BITS];
    work_next.quo      = request.dividend[WORD_BITS-1:0];
    work_next.divisor  = request.divisor;
    work_next.overflow = (request.divisor <= request.dividend[2*WORD_BITS-1:WORD_BITS]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= load || (valid && work_full);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      work <= work_next;
    end
  end

endmodule

@@ src/ud32_step.sv @@
// ----------------------------------------------------------------------------
// ud32_step
// one registered restoring division step, overflow items pass unchanged
// ----------------------------------------------------------------------------
module ud32_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid_in,
  input  ud32_pkg::work_t work_in,
  output logic            valid_out,
  output ud32_pkg::work_t work_out
);

  import ud32_pkg::*;

  logic [WORD_BITS:0]   shifted;
  logic [WORD_BITS+1:0] trial;
  work_t                work_next;

  always_comb begin
    shifted   = {work_in.rem, work_in.quo[WORD_BITS-1]};
    trial     = {1'b0, shifted} - {2'b00, work_in.divisor};
    work_next = work_in;
    if (!work_in.overflow) begin
      if (!trial[WORD_BITS+1]) begin
        work_next.rem = trial[WORD_BITS-1:0];
        work_next.quo = {work_in.quo[WORD_BITS-2:0], 1'b1};
      end else begin
        work_next.rem = shifted[WORD_BITS-1:0];
        work_next.quo = {work_in.quo[WORD_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_in) begin
      work_out <= work_next;
    end
  end

endmodule

@@ src/ud32_back.sv @@
// ----------------------------------------------------------------------------
// ud32_back
// division pipeline fed by credit from the result queue, never stalls inside
// ----------------------------------------------------------------------------
`include "unsigned_divide_32_by_16_overflow_defines.svh"

module ud32_back #(
  parameter int OUT_DEPTH = ud32_pkg::OUT_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               work_empty,
  output logic               work_pop,
  input  ud32_pkg::work_t    work,
  output logic               empty,
  input  logic               pop,
  output ud32_pkg::result_t  result
);

  import ud32_pkg::*;

  localparam int HELD_BITS = $clog2(OUT_DEPTH + 1);

  logic [HELD_BITS-1:0] held;
  logic                 issue;
  logic                 out_pop;
  logic                 out_full;
  logic                 valid_pipe [WORD_BITS+1];
  work_t                work_pipe  [WORD_BITS+1];
  result_t              out_item;

  // items in the pipeline plus items in the result queue
  assign issue    = !work_empty && (held != HELD_BITS'(OUT_DEPTH));
  assign work_pop = issue;
  assign out_pop  = pop && !empty;

  assign valid_pipe[0] = issue;
  assign work_pipe[0]  = work;

  for (genvar g = 0; g < WORD_BITS; g++) begin : g_step
    ud32_step u_step (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (valid_pipe[g]),
      .work_in   (work_pipe[g]),
      .valid_out (valid_pipe[g+1]),
      .work_out  (work_pipe[g+1])
    );
  end

  always_comb begin
    out_item.quotient  = work_pipe[WORD_BITS].quo;
    out_item.remainder = work_pipe[WORD_BITS].rem;
    out_item.overflow  = work_pipe[WORD_BITS].overflow;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (issue && !out_pop) begin
      held <= held + 1'b1;
    end else if (out_pop && !issue) begin
      held <= held - 1'b1;
    end
  end

  ud32_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (valid_pipe[WORD_BITS]),
    .full  (out_full),
    .din   (out_item),
    .pop   (pop),
    .empty (empty),
    .dout  (result)
  );

  `UD32_ASSERT_IMPL(a_out_no_overrun, valid_pipe[WORD_BITS], !out_full, "result queue overrun")
  `UD32_ASSERT_IMPL(a_held_bound, 1'b1, held <= HELD_BITS'(OUT_DEPTH), "credit count too high")
  `UD32_ASSERT_NEXT(a_held_drop, out_pop && !issue, held == $past(held) - 1'b1, "credit not returned")
  `UD32_ASSERT_IMPL(a_empty_no_credit, held == '0, empty && !valid_pipe[WORD_BITS], "item without credit")

endmodule

@@ src/unsigned_divide_32_by_16_overflow.sv @@
// ----------------------------------------------------------------------------
// unsigned_divide_32_by_16_overflow
// unsigned 32 by 16 divide with overflow flag, while not full one item per clock
// ----------------------------------------------------------------------------
// Takes a 32-bit dividend and a 16-bit divisor and returns quotient,
// remainder and an overflow flag. Overflow is raised when the divisor is
// not greater than the dividend high word (a zero divisor included); the
// quotient then carries the dividend low word and the remainder its high
// word, so the destination is left as it was. A new item is taken every
// clock while full is low, and a result can be taken every clock while
// empty is low. On its way to the result side an accepted item passes
// through the front register, the short queue and the restoring steps
// (16 pipelined steps, each one 17-bit subtract), and is then pushed
// into the result queue. The result queue holds every item that has
// entered the step pipeline, so the pipeline itself never stalls; when
// pop stays low the pipeline drains into it and full rises once the
// result queue, the short queue and the front register are all taken.
// ----------------------------------------------------------------------------
module unsigned_divide_32_by_16_overflow #(
  parameter int MID_DEPTH = ud32_pkg::MID_DEPTH,  // front to back queue
  parameter int OUT_DEPTH = ud32_pkg::OUT_DEPTH   // step count plus two keeps one item per clock
) (
  input  logic               clk,
  input  logic               rst,
  // request side
  input  logic               push,
  output logic               full,
  input  ud32_pkg::request_t request,
  // result side
  output logic               empty,
  input  logic               pop,
  output ud32_pkg::result_t  result
);

  import ud32_pkg::*;

  // classified items from the front
  logic  front_push;
  logic  front_full;
  work_t front_work;

  // short queue towards the division pipeline
  logic  mid_empty;
  logic  mid_pop;
  work_t mid_work;

  // accept, compare divisor against high word, register
  ud32_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .work_push (front_push),
    .work_full (front_full),
    .work      (front_work)
  );

  // lets front and back stall on their own
  ud32_queue #(
    .WIDTH ($bits(work_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .full  (front_full),
    .din   (front_work),
    .pop   (mid_pop),
    .empty (mid_empty),
    .dout  (mid_work)
  );

  // restoring division pipeline and result queue
  ud32_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .work_empty (mid_empty),
    .work_pop   (mid_pop),
    .work       (mid_work),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

@@ tb/unsigned_divide_32_by_16_overflow_test.sv @@
// ----------------------------------------------------------------------------
// unsigned_divide_32_by_16_overflow_test
// self-checking bench for the unsigned 32 by 16 divider with overflow flag
// ----------------------------------------------------------------------------
// Items are offered on the request queue side and each accepted item is
// predicted on the spot by a bit-level restoring divider kept in the bench.
// Results are taken from the result queue side and compared field by field,
// oldest first. Runs a directed set of corner cases, then random mixes of
// fitting, overflowing and unconstrained divisions, a long result-side hold
// that fills the block, a pause until drained, large divisors, and a final
// stretch with no idling on either side.
// ----------------------------------------------------------------------------
module unsigned_divide_32_by_16_overflow_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ud32_pkg::*;

  // cycles with nothing accepted on either side before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  // settle time after the last result, comfortably above the pipeline depth
  localparam int SETTLE_CYCLES = 40;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     push = 1'b0;
  logic     pop = 1'b0;
  logic     full;
  logic     empty;
  request_t request = '0;
  result_t  result;

  // predicted results, oldest at the front
  result_t pending_results[$];
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  // result side hold-off requested by a test, counted down by the receiver
  int      hold_cycles = 0;
  int      pop_gap = 0;
  // no idling on either side once set
  bit      calm = 1'b0;

  unsigned_divide_32_by_16_overflow u_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bit-level restoring divide with a 17-bit partial remainder
  function automatic result_t predict_divide(request_t req);
    logic [WORD_BITS:0]   part;
    logic [WORD_BITS-1:0] high_word;
    logic [WORD_BITS-1:0] low_word;
    logic [WORD_BITS-1:0] quo;
    result_t              res;
    high_word = req.dividend[2*WORD_BITS-1:WORD_BITS];
    low_word  = req.dividend[WORD_BITS-1:0];
    if (req.divisor <= high_word) begin
      // quotient would not fit: destination handed back untouched
      res.quotient  = low_word;
      res.remainder = high_word;
      res.overflow  = 1'b1;
    end else begin
      part = {1'b0, high_word};
      quo  = low_word;
      for (int i = 0; i < WORD_BITS; i++) begin
        part = {part[WORD_BITS-1:0], quo[WORD_BITS-1]};
        quo  = quo << 1;
        if (part >= {1'b0, req.divisor}) begin
          part   = part - {1'b0, req.divisor};
          quo[0] = 1'b1;
        end
      end
      res.quotient  = quo;
      res.remainder = part[WORD_BITS-1:0];
      res.overflow  = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // offers one item and returns at the edge where it is taken; push is left
  // high so that a following call keeps the stream going without a gap
  task automatic send_request(input logic [2*WORD_BITS-1:0] dividend,
                              input logic [WORD_BITS-1:0] divisor);
    request_t item;
    item.dividend = dividend;
    item.divisor  = divisor;
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push    <= 1'b1;
    request <= item;
    do @(posedge clk); while (full);
  endtask

  // random division; mostly quotients that fit, some overflows, some anything
  task automatic send_random(input bit big_divisor);
    logic [WORD_BITS-1:0] high_word;
    logic [WORD_BITS-1:0] low_word;
    logic [WORD_BITS-1:0] divisor;
    int                   pick;
    pick     = $urandom_range(0, 19);
    low_word = WORD_BITS'($urandom);
    if (big_divisor)
      divisor = WORD_BITS'($urandom_range(16'h8000, 16'hffff));
    else if ($urandom_range(0, 3) == 0)
      divisor = WORD_BITS'($urandom_range(0, 15));
    else
      divisor = WORD_BITS'($urandom);
    if (pick < 14) begin
      if (divisor == '0)
        divisor = WORD_BITS'(1);
      high_word = WORD_BITS'($urandom_range(0, int'(divisor) - 1));
    end else if (pick < 17) begin
      high_word = WORD_BITS'($urandom_range(int'(divisor), 16'hffff));
    end else begin
      high_word = WORD_BITS'($urandom);
    end
    send_request({high_word, low_word}, divisor);
  endtask

  // stop offering and wait for every predicted result to come back
  task automatic wait_drained();
    push <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  // zero divisor, divisor at and just above the high word, largest quotient,
  // carry out of the partial remainder with divisors from 0x8000 up
  task automatic test_corner_cases();
    logic [2*WORD_BITS-1:0] dividends[18] = '{
      32'h0000_0000, 32'h1234_5678, 32'hffff_ffff, 32'hffff_ffff,
      32'h0005_0007, 32'h0005_0007, 32'h0000_ffff, 32'hfffe_ffff,
      32'h7fff_ffff, 32'h7fff_0000, 32'h8000_0000, 32'hfffe_0000,
      32'h0000_0000, 32'h0000_ffff, 32'h0000_0001, 32'habcd_1234,
      32'h0000_1234, 32'h5555_aaaa
    };
    logic [WORD_BITS-1:0] divisors[18] = '{
      16'h0000, 16'h0000, 16'h0000, 16'hffff,
      16'h0005, 16'h0006, 16'hffff, 16'hffff,
      16'h8000, 16'h8000, 16'h8001, 16'hffff,
      16'h0001, 16'h0001, 16'hffff, 16'habce,
      16'h1234, 16'haaaa
    };
    foreach (dividends[i])
      send_request(dividends[i], divisors[i]);
  endtask

  task automatic test_random_mix();
    repeat (450) send_random(1'b0);
  endtask

  // receiver holds off while the sender keeps offering, so full must rise
  task automatic test_result_hold();
    hold_cycles = 150;
    repeat (80) send_random(1'b0);
    wait_drained();
  endtask

  // sender goes quiet until the block has handed back everything
  task automatic test_drain_pause();
    repeat (50) send_random(1'b0);
    wait_drained();
    repeat (50) send_random(1'b0);
  endtask

  task automatic test_large_divisors();
    repeat (150) send_random(1'b1);
  endtask

  // back to back on both sides
  task automatic test_full_rate();
    calm = 1'b1;
    repeat (350) send_random(1'b0);
  endtask

  // predict every item the block takes
  always @(posedge clk) begin
    if (!rst && push && !full)
      pending_results.push_back(predict_divide(request));
  end

  // result side: random stall bursts, a long hold on request, none when calm
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_cycles > 0) begin
      pop <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else if (calm) begin
      pop <= 1'b1;
    end else if (pop_gap > 0) begin
      pop <= 1'b0;
      pop_gap = pop_gap - 1;
    end else if ($urandom_range(0, 6) == 0) begin
      pop <= 1'b0;
      pop_gap = $urandom_range(0, 2);
    end else begin
      pop <= 1'b1;
    end
  end

  // compare each result taken with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item pending", 32'(result), '0);
      end else begin
        want = pending_results.pop_front();
        if (result.quotient !== want.quotient)
          report_mismatch("quotient", 32'(result.quotient), 32'(want.quotient));
        if (result.remainder !== want.remainder)
          report_mismatch("remainder", 32'(result.remainder), 32'(want.remainder));
        if (result.overflow !== want.overflow)
          report_mismatch("overflow", 32'(result.overflow), 32'(want.overflow));
      end
    end
  end

  // watchdog on progress of either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_cases();
    test_random_mix();
    test_result_hold();
    test_drain_pause();
    test_large_divisors();
    test_full_rate();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/ud32_pkg.sv
src/ud32_queue.sv
src/ud32_front.sv
src/ud32_step.sv
src/ud32_back.sv
src/unsigned_divide_32_by_16_overflow.sv
tb/unsigned_divide_32_by_16_overflow_test.sv
